### sv/assert_macros.svh
// Assertion macros used by the checker file pobk_checker.sv.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/pobk_pkg.sv
// Package for the price level order book: sizes, result kinds and sequencer states.
// Used by the core and the checker; depends on nothing.
package pobk_pkg;

    localparam int LEVELS    = 64;
    localparam int LW        = $clog2(LEVELS);
    localparam int CW        = $clog2(LEVELS + 1);
    localparam int MAX_DEPTH = 16;
    localparam int DW        = 5;
    localparam int PW        = 32;
    localparam int QW        = 40;
    localparam int EW        = PW + QW;
    localparam int IN_TW     = 80;
    localparam int OUT_TW    = 224;
    localparam logic [DW-1:0] DEPTH_RESET = 5'd10;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    localparam logic [1:0] KIND_QUOTE = 2'd0;
    localparam logic [1:0] KIND_LEVEL = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_DECIDE, ST_DEL_RD, ST_DEL_WR,
        ST_INS_RD, ST_INS_WR, ST_FINISH, ST_Q_BID, ST_Q_OUT, ST_SNAP_RD,
        ST_SNAP_OUT, ST_EMPTY_OUT
    } state_t;

    typedef struct packed {
        logic          rd_en;
        logic [LW:0]   rd_addr;
        logic          wr_en;
        logic [LW:0]   wr_addr;
        logic [EW-1:0] wr_data;
    } mem_ctl_t;

endpackage

### sv/pobk_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Depends on nothing; holds the level entries of both book sides.
module pobk_ram #(
    parameter int AW = 7,
    parameter int DATA_W = 72
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/price_level_order_book_core.sv
// Order book core: bid and ask price levels kept sorted in one RAM, quotes and snapshots out.
// Depends on pobk_pkg and pobk_ram. One item at a time; s_tready is high only in idle.
// Update: a scan reads each level ranked ahead of its price, a decide step follows, each level
// moved on insert or delete is read and then written, and a finish step ends it; a quote then
// reads the bid and ask tops into the output register. A snapshot sends its words one at a time.
// Reset clears counts, overflow and depth (to 10); RAM is not cleared.
module price_level_order_book_core
    import pobk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DW-1:0]     cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // side[0], price[32:1], qty[72:33], zeros
    input  logic              s_tuser,   // op
    input  logic              s_tlast,   // end_of_message
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // bid_price, bid_qty, ask_price, ask_qty, level_side,
                                         // level_rank, level_price, level_qty, overflow, zeros
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast    // last
);

    state_t state_reg, state_next;
    logic          side_reg, side_next;
    logic [PW-1:0] price_reg, price_next;
    logic [QW-1:0] qty_reg, qty_next;
    logic          eom_reg, eom_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic          found_reg, found_next;
    logic [CW-1:0] bid_cnt_reg, bid_cnt_next;
    logic [CW-1:0] ask_cnt_reg, ask_cnt_next;
    logic          ovf_reg, ovf_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          ss_reg, ss_next;
    logic [DW-1:0] si_reg, si_next;
    logic [DW-1:0] lim_b_reg, lim_b_next;
    logic [DW-1:0] lim_a_reg, lim_a_next;
    logic [EW-1:0] hold_reg, hold_next;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_TW-1:0] out_data_reg, out_data_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    mem_ctl_t      mc;
    logic [EW-1:0] rd_data;
    logic [PW-1:0] rd_price;
    logic [QW-1:0] rd_qty;
    logic          out_free;
    logic          accept;
    logic [CW-1:0] cnt;
    logic          better;
    logic [DW-1:0] dclamp;
    logic [DW-1:0] lim_b_c, lim_a_c;
    logic [DW-1:0] si_inc;
    logic          snap_last;
    logic [DW-1:0] cur_lim;

    pobk_ram #(.AW(LW + 1), .DATA_W(EW)) u_ram (
        .clk     (clk),
        .rd_en   (mc.rd_en),
        .rd_addr (mc.rd_addr),
        .rd_data (rd_data),
        .wr_en   (mc.wr_en),
        .wr_addr (mc.wr_addr),
        .wr_data (mc.wr_data)
    );

    assign rd_price = rd_data[PW-1:0];
    assign rd_qty   = rd_data[EW-1:PW];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cnt      = side_reg ? ask_cnt_reg : bid_cnt_reg;
    assign better   = side_reg ? (rd_price < price_reg) : (rd_price > price_reg);
    assign dclamp   = (depth_reg > DW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : depth_reg;
    assign lim_b_c  = (bid_cnt_reg < CW'(dclamp)) ? DW'(bid_cnt_reg) : dclamp;
    assign lim_a_c  = (ask_cnt_reg < CW'(dclamp)) ? DW'(ask_cnt_reg) : dclamp;
    assign si_inc   = si_reg + DW'(1);
    assign cur_lim  = ss_reg ? lim_a_reg : lim_b_reg;
    assign snap_last = ss_reg ? (si_inc == lim_a_reg)
                              : ((si_inc == lim_b_reg) && (lim_a_reg == '0));

    // Next state and datapath registers.
    always_comb
    begin
        state_next   = state_reg;
        side_next    = side_reg;
        price_next   = price_reg;
        qty_next     = qty_reg;
        eom_next     = eom_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        found_next   = found_reg;
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        ovf_next     = ovf_reg;
        depth_next   = cfg_we ? cfg_wdata : depth_reg;
        ss_next      = ss_reg;
        si_next      = si_reg;
        lim_b_next   = lim_b_reg;
        lim_a_next   = lim_a_reg;
        hold_next    = hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    side_next  = s_tdata[0];
                    price_next = s_tdata[PW:1];
                    qty_next   = s_tdata[EW:PW+1];
                    eom_next   = s_tlast;
                    idx_next   = '0;
                    ss_next    = 1'b0;
                    si_next    = '0;
                    lim_b_next = lim_b_c;
                    lim_a_next = lim_a_c;
                    if (s_tuser == OP_SNAPSHOT)
                    begin
                        state_next = ((lim_b_c == '0) && (lim_a_c == '0)) ? ST_EMPTY_OUT
                                                                          : ST_SNAP_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (idx_reg == cnt)
                begin
                    found_next = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (better)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    found_next = (rd_price == price_reg);
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (qty_reg == '0)
                begin
                    j_next     = idx_reg;
                    state_next = found_reg ? ST_DEL_RD : ST_FINISH;
                end
                else if (found_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (cnt == CW'(LEVELS))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    j_next     = cnt;
                    state_next = ST_INS_RD;
                end
            end
            ST_DEL_RD:
            begin
                if ((j_reg + CW'(1)) < cnt)
                begin
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    if (side_reg)
                    begin
                        ask_cnt_next = ask_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        bid_cnt_next = bid_cnt_reg - CW'(1);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_DEL_WR:
            begin
                j_next     = j_reg + CW'(1);
                state_next = ST_DEL_RD;
            end
            ST_INS_RD:
            begin
                if (j_reg > idx_reg)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    if (side_reg)
                    begin
                        ask_cnt_next = ask_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        bid_cnt_next = bid_cnt_reg + CW'(1);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_INS_WR:
            begin
                j_next     = j_reg - CW'(1);
                state_next = ST_INS_RD;
            end
            ST_FINISH:
            begin
                if (eom_reg && (bid_cnt_reg != '0) && (ask_cnt_reg != '0))
                begin
                    state_next = ST_Q_BID;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_BID:
            begin
                hold_next  = rd_data;
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SNAP_RD:
            begin
                if (si_reg < cur_lim)
                begin
                    state_next = ST_SNAP_OUT;
                end
                else if (!ss_reg)
                begin
                    ss_next = 1'b1;
                    si_next = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SNAP_OUT:
            begin
                if (out_free)
                begin
                    si_next    = si_inc;
                    state_next = snap_last ? ST_IDLE : ST_SNAP_RD;
                end
            end
            ST_EMPTY_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM control and output stage loading.
    always_comb
    begin
        mc             = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_SCAN_RD:
            begin
                mc.rd_en   = (idx_reg != cnt);
                mc.rd_addr = {side_reg, idx_reg[LW-1:0]};
            end
            ST_DEL_RD:
            begin
                mc.rd_en   = ((j_reg + CW'(1)) < cnt);
                mc.rd_addr = {side_reg, LW'(j_reg + CW'(1))};
            end
            ST_DEL_WR:
            begin
                mc.wr_en   = 1'b1;
                mc.wr_addr = {side_reg, j_reg[LW-1:0]};
                mc.wr_data = rd_data;
            end
            ST_DECIDE:
            begin
                // Existing price: the quantity is replaced in place.
                mc.wr_en   = (qty_reg != '0) && found_reg;
                mc.wr_addr = {side_reg, idx_reg[LW-1:0]};
                mc.wr_data = {qty_reg, price_reg};
            end
            ST_INS_RD:
            begin
                mc.rd_en   = (j_reg > idx_reg);
                mc.rd_addr = {side_reg, LW'(j_reg - CW'(1))};
                mc.wr_en   = !(j_reg > idx_reg);
                mc.wr_addr = {side_reg, idx_reg[LW-1:0]};
                mc.wr_data = {qty_reg, price_reg};
            end
            ST_INS_WR:
            begin
                mc.wr_en   = 1'b1;
                mc.wr_addr = {side_reg, j_reg[LW-1:0]};
                mc.wr_data = rd_data;
            end
            ST_FINISH:
            begin
                mc.rd_en   = 1'b1;
                mc.rd_addr = {1'b0, LW'(0)};
            end
            ST_Q_BID:
            begin
                mc.rd_en   = 1'b1;
                mc.rd_addr = {1'b1, LW'(0)};
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_QUOTE;
                    out_last_next  = 1'b1;
                    out_data_next  = {2'b0, ovf_reg, QW'(0), PW'(0), 4'b0, 1'b0,
                                      rd_qty, rd_price, hold_reg[EW-1:PW], hold_reg[PW-1:0]};
                end
            end
            ST_SNAP_RD:
            begin
                mc.rd_en   = (si_reg < cur_lim);
                mc.rd_addr = {ss_reg, LW'(si_reg)};
            end
            ST_SNAP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LEVEL;
                    out_last_next  = snap_last;
                    out_data_next  = {2'b0, ovf_reg, rd_qty, rd_price, si_reg[3:0], ss_reg,
                                      QW'(0), PW'(0), QW'(0), PW'(0)};
                end
            end
            ST_EMPTY_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EMPTY;
                    out_last_next  = 1'b1;
                    out_data_next  = {2'b0, ovf_reg, 221'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bid_cnt_reg   <= '0;
            ask_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            depth_reg     <= DEPTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bid_cnt_reg   <= bid_cnt_next;
            ask_cnt_reg   <= ask_cnt_next;
            ovf_reg       <= ovf_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg     <= side_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        eom_reg      <= eom_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        found_reg    <= found_next;
        ss_reg       <= ss_next;
        si_reg       <= si_next;
        lim_b_reg    <= lim_b_next;
        lim_a_reg    <= lim_a_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### sv/pobk_checker.sv
// Port checker for the order book core, attached by bind.
// Depends on pobk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pobk_checker
    import pobk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_TW-1:0] m_tdata,
    input logic [1:0]        m_tuser,
    input logic              m_tlast
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPL(a_quote_last, m_tvalid && (m_tuser == KIND_QUOTE), m_tlast)
    `ASSERT_IMPL(a_empty_last, m_tvalid && (m_tuser == KIND_EMPTY), m_tlast)
    `ASSERT_NEXT(a_ovf_sticky, m_tvalid && m_tready && m_tdata[221], !m_tvalid || m_tdata[221])
    // An accepted word always takes the block out of idle in the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind price_level_order_book_core pobk_checker u_pobk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
